// ===== hdl/srpg_pkg.sv =====
// package for the servo range pwm generator
// holds word types, command and register codes and controller types; no dependencies
package srpg_pkg;

  localparam int TIME_BITS = 20;
  localparam int DUTY_BITS = 7;
  localparam int PROD1_BITS = TIME_BITS + DUTY_BITS;
  localparam int RECIP_BITS = 26;
  localparam int PROD2_BITS = PROD1_BITS + RECIP_BITS;

  localparam logic [DUTY_BITS-1:0] MAX_DUTY = 7'd100;
  localparam logic [RECIP_BITS-1:0] DIV100_MUL = 26'h28f5c29;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_DUTY = 2'd1,
    CMD_START    = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH_LO     = 2'd0,
    REG_WIDTH_HI     = 2'd1,
    REG_PERIOD       = 2'd2,
    REG_INITIAL_DUTY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [DUTY_BITS-1:0] duty;
  } in_word_t;

  typedef struct packed {
    logic                 pwm_out;
    logic                 status;
    logic                 running;
    logic [DUTY_BITS-1:0] active_duty;
    logic [TIME_BITS-1:0] pulse_us;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_width;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/srpg_controller.sv =====
// controller state machine for the servo range pwm generator
// sequences the pulse width multiply; depends on srpg_pkg
module srpg_controller import srpg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !stat.out_busy && stat.need_width) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.accept = 1'b0;
    ctl.mul1   = 1'b0;
    ctl.mul2   = 1'b0;
    ctl.load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = !stat.out_busy;
        ctl.accept = in_valid && !stat.out_busy;
      end
      ST_MUL1: ctl.mul1 = 1'b1;
      ST_MUL2: ctl.mul2 = 1'b1;
      ST_LOAD: ctl.load = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== hdl/srpg_datapath.sv =====
// datapath for the servo range pwm generator
// config registers, counters, width multiplier and output register; depends on srpg_pkg
module srpg_datapath import srpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  reg_idx_t             cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  input  in_word_t             in_data,
  input  ctl_cmd_t             ctl,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data
);

  logic [TIME_BITS-1:0] width_lo_r, width_hi_r, period_r;
  logic [DUTY_BITS-1:0] initial_duty_r;

  logic                 run_flag_r, run_flag_nxt;
  logic [TIME_BITS-1:0] period_count_r, period_count_nxt;
  logic [TIME_BITS-1:0] pulse_left_r, pulse_left_nxt;
  logic [TIME_BITS-1:0] pulse_width_r, pulse_width_nxt;
  logic                 out_level_r, out_level_nxt;
  logic [DUTY_BITS-1:0] current_duty_r, current_duty_nxt;
  logic [DUTY_BITS-1:0] pending_duty_r, pending_duty_nxt;
  logic                 update_pending_r, update_pending_nxt;
  logic                 duty_given_r, duty_given_nxt;
  logic                 status_nxt;
  logic                 need_width;

  logic [PROD1_BITS-1:0] prod1_r;
  logic [PROD2_BITS-1:0] prod2;
  logic [TIME_BITS-1:0]  prod_hi_r;
  logic [TIME_BITS-1:0]  span;
  logic [TIME_BITS-1:0]  new_width;
  logic                  reversed;

  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_lo_r     <= 20'd1000;
      width_hi_r     <= 20'd2000;
      period_r       <= 20'd20000;
      initial_duty_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_LO:     width_lo_r     <= cfg_data;
        REG_WIDTH_HI:     width_hi_r     <= cfg_data;
        REG_PERIOD:       period_r       <= cfg_data;
        REG_INITIAL_DUTY: initial_duty_r <= cfg_data[DUTY_BITS-1:0];
        default:          width_lo_r     <= width_lo_r;
      endcase
    end
  end

  // word update; a period start with a new duty leaves the width to the multiplier
  always_comb begin
    logic [TIME_BITS-1:0] per;
    per = (period_r == '0) ? {{(TIME_BITS-1){1'b0}}, 1'b1} : period_r;
    run_flag_nxt       = run_flag_r;
    period_count_nxt   = period_count_r;
    pulse_left_nxt     = pulse_left_r;
    pulse_width_nxt    = pulse_width_r;
    out_level_nxt      = out_level_r;
    current_duty_nxt   = current_duty_r;
    pending_duty_nxt   = pending_duty_r;
    update_pending_nxt = update_pending_r;
    duty_given_nxt     = duty_given_r;
    status_nxt         = 1'b0;
    need_width         = 1'b0;
    case (in_data.cmd)
      CMD_TICK: begin
        if (run_flag_r) begin
          if (pulse_left_r != '0) begin
            pulse_left_nxt = pulse_left_r - 1'b1;
            if (pulse_left_nxt == '0) begin
              out_level_nxt = 1'b0;
            end
          end
          period_count_nxt = period_count_r + 1'b1;
          if (period_count_nxt >= per) begin
            period_count_nxt = '0;
            if (update_pending_r) begin
              current_duty_nxt   = pending_duty_r;
              update_pending_nxt = 1'b0;
              need_width         = 1'b1;
            end else begin
              pulse_left_nxt = pulse_width_r;
              out_level_nxt  = (pulse_width_r != '0);
            end
          end
        end
      end
      CMD_SET_DUTY: begin
        if (in_data.duty > MAX_DUTY) begin
          status_nxt = 1'b1;
        end else begin
          pending_duty_nxt   = in_data.duty;
          update_pending_nxt = 1'b1;
          duty_given_nxt     = 1'b1;
        end
      end
      CMD_START: begin
        if (!duty_given_r) begin
          pending_duty_nxt = (initial_duty_r > MAX_DUTY) ? MAX_DUTY : initial_duty_r;
        end
        update_pending_nxt = 1'b1;
        period_count_nxt   = '0;
        run_flag_nxt       = 1'b1;
      end
      CMD_STOP: begin
        out_level_nxt    = 1'b0;
        run_flag_nxt     = 1'b0;
        period_count_nxt = '0;
        pulse_left_nxt   = '0;
      end
      default: status_nxt = 1'b0;
    endcase
  end

  assign stat.need_width = need_width;
  assign stat.out_busy   = out_valid_r && !out_ready;

  // width = lo + (span * duty * recip) >> 32, over two multiplier stages
  assign reversed  = (width_hi_r <= width_lo_r);
  assign span      = width_hi_r - width_lo_r;
  assign prod2     = PROD2_BITS'(prod1_r) * PROD2_BITS'(DIV100_MUL);
  assign new_width = reversed ? width_lo_r : width_lo_r + prod_hi_r;

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      prod1_r <= PROD1_BITS'(span) * PROD1_BITS'(current_duty_r);
    end
    if (ctl.mul2) begin
      prod_hi_r <= prod2[32 +: TIME_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r       <= 1'b0;
      period_count_r   <= '0;
      pulse_left_r     <= '0;
      pulse_width_r    <= '0;
      out_level_r      <= 1'b0;
      current_duty_r   <= '0;
      pending_duty_r   <= '0;
      update_pending_r <= 1'b0;
      duty_given_r     <= 1'b0;
    end else if (ctl.accept) begin
      run_flag_r       <= run_flag_nxt;
      period_count_r   <= period_count_nxt;
      pulse_left_r     <= pulse_left_nxt;
      pulse_width_r    <= pulse_width_nxt;
      out_level_r      <= out_level_nxt;
      current_duty_r   <= current_duty_nxt;
      pending_duty_r   <= pending_duty_nxt;
      update_pending_r <= update_pending_nxt;
      duty_given_r     <= duty_given_nxt;
    end else if (ctl.load) begin
      pulse_width_r <= new_width;
      pulse_left_r  <= new_width;
      out_level_r   <= (new_width != '0);
    end
  end

  always_comb begin
    if (ctl.load) begin
      word_nxt.pwm_out     = (new_width != '0);
      word_nxt.status      = 1'b0;
      word_nxt.running     = run_flag_r;
      word_nxt.active_duty = current_duty_r;
      word_nxt.pulse_us    = new_width;
    end else begin
      word_nxt.pwm_out     = out_level_nxt;
      word_nxt.status      = status_nxt;
      word_nxt.running     = run_flag_nxt;
      word_nxt.active_duty = current_duty_nxt;
      word_nxt.pulse_us    = pulse_width_nxt;
    end
  end

  // output register; loads only when the slot is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.accept && !need_width) || ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.accept && !need_width) || ctl.load) begin
      out_data_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/servo_range_pwm_generator.sv =====
// top level of the servo range pwm generator
// joins srpg_controller and srpg_datapath; depends on srpg_pkg
//
// Each input word is one command: a one-microsecond tick, set duty, start or
// stop, and each gives exactly one result word with the pin level, the reject
// status, the run flag, the duty in force and the pulse width. Most words have
// their result registered on acceptance; a tick that begins a period while a new
// duty is pending is held back, since the pulse width
// lo + (span * duty * 0x28f5c29) >> 32, lo being the zero-duty width, goes
// through two registered multiplier stages and a load step. A registered
// output slot lets the next word enter in the cycle its predecessor's result
// is taken. Configuration writes (index 0 zero-duty width, 1 full-duty width,
// 2 period, 3 initial duty) are always ready and must be made while the block
// is idle.
module servo_range_pwm_generator import srpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  srpg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  srpg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (reg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
// testbench for servo_range_pwm_generator: drives command words, predicts each result word
// and checks the results in order; depends on srpg_pkg and the block's RTL
module tb_top;
  import srpg_pkg::*;

  localparam logic [19:0] TIME_ALL_ONES = 20'hfffff;
  localparam logic [6:0]  DUTY_CEIL     = 7'd100;
  localparam logic [63:0] RECIP_100     = 64'h28f5c29;
  localparam int          RANDOM_WORDS  = 500;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data  = '0;

  // register copies, reset values
  logic [19:0] reg_min       = 20'd1000;
  logic [19:0] reg_max       = 20'd2000;
  logic [19:0] reg_period    = 20'd20000;
  logic [6:0]  reg_init_duty = 7'd0;

  // predicted generator state
  logic        run_on       = 1'b0;
  logic [19:0] base_cnt     = '0;
  logic [19:0] pulse_cnt    = '0;
  logic [19:0] pulse_len    = '0;
  logic        pin          = 1'b0;
  logic [6:0]  duty_now     = '0;
  logic [6:0]  duty_next    = '0;
  logic        duty_waiting = 1'b0;
  logic        duty_seen    = 1'b0;

  out_word_t pin_words_due[$];
  out_word_t want_word;
  int        mismatches  = 0;
  int        burst_left  = 0;
  int        stall_mode  = 0;
  int        mode_left   = 0;
  int        stall_phase = 0;

  servo_range_pwm_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // floor(span * pct / 100) by reciprocal multiply; reversed range gives the minimum
  function automatic logic [19:0] width_at(input logic [6:0] pct);
    logic [63:0] scaled;
    if (reg_max <= reg_min) return reg_min;
    scaled = (64'(reg_max - reg_min) * 64'(pct) * RECIP_100) >> 32;
    return reg_min + scaled[19:0];
  endfunction

  function automatic out_word_t step_servo(input in_word_t w);
    out_word_t   r;
    logic [19:0] per;
    logic        rej;
    rej = 1'b0;
    per = (reg_period == '0) ? 20'd1 : reg_period;
    case (w.cmd)
      CMD_TICK: begin
        if (run_on) begin
          if (pulse_cnt != '0) begin
            pulse_cnt = pulse_cnt - 1'b1;
            if (pulse_cnt == '0) pin = 1'b0;
          end
          base_cnt = base_cnt + 1'b1;
          if (base_cnt >= per) begin
            base_cnt = '0;
            pin = 1'b1;
            if (duty_waiting) begin
              duty_now = duty_next;
              pulse_len = width_at(duty_now);
              duty_waiting = 1'b0;
            end
            pulse_cnt = pulse_len;
            if (pulse_cnt == '0) pin = 1'b0;
          end
        end
      end
      CMD_SET_DUTY: begin
        if (w.duty > DUTY_CEIL) begin
          rej = 1'b1;
        end else begin
          duty_next = w.duty;
          duty_waiting = 1'b1;
          duty_seen = 1'b1;
        end
      end
      CMD_START: begin
        if (!duty_seen) duty_next = (reg_init_duty > DUTY_CEIL) ? DUTY_CEIL : reg_init_duty;
        duty_waiting = 1'b1;
        base_cnt = '0;
        run_on = 1'b1;
      end
      default: begin
        pin = 1'b0;
        run_on = 1'b0;
        base_cnt = '0;
        pulse_cnt = '0;
      end
    endcase
    r.pwm_out = pin;
    r.status = rej;
    r.running = run_on;
    r.active_duty = duty_now;
    r.pulse_us = pulse_len;
    return r;
  endfunction

  task automatic send_word(input cmd_t c, input logic [6:0] d);
    in_word_t w;
    int       gap;
    w.cmd = c;
    w.duty = d;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pin_words_due.push_back(step_servo(w));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(CMD_TICK, 7'($urandom_range(0, 127)));
  endtask

  // every word gives a result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pin_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH_LO: reg_min = val;
      REG_WIDTH_HI: reg_max = val;
      REG_PERIOD:   reg_period = val;
      default:      reg_init_duty = val[6:0];
    endcase
  endtask

  task automatic program_regs(input logic [19:0] lo, input logic [19:0] hi,
                              input logic [19:0] per, input logic [19:0] init);
    wait_idle();
    write_reg(REG_WIDTH_LO, lo);
    write_reg(REG_WIDTH_HI, hi);
    write_reg(REG_PERIOD, per);
    write_reg(REG_INITIAL_DUTY, init);
    cfg_valid <= 1'b0;
  endtask

  // no duty set yet, so start takes the initial duty, clipped to 100
  task automatic test_initial_duty_saturation();
    program_regs(20'd0, TIME_ALL_ONES, 20'd1, 20'd127);
    send_word(CMD_START, 7'd127);
    send_ticks(2);
    send_word(CMD_STOP, 7'd0);
    send_word(CMD_STOP, 7'd127);
    send_word(CMD_TICK, 7'd0);
  endtask

  task automatic test_duty_commands();
    program_regs(20'd3, 20'd9, 20'd4, 20'd0);
    send_word(CMD_SET_DUTY, 7'd127);
    send_word(CMD_SET_DUTY, 7'd101);
    send_word(CMD_SET_DUTY, 7'd85);
    send_word(CMD_START, 7'd42);
    send_ticks(5);
    send_word(CMD_SET_DUTY, 7'd0);
    send_ticks(4);
  endtask

  // reversed range, then zero width with zero period
  task automatic test_range_corners();
    program_regs(20'd7, 20'd3, 20'd3, 20'd50);
    send_word(CMD_SET_DUTY, 7'd60);
    send_ticks(3);
    program_regs(20'd0, 20'd0, 20'd0, 20'd0);
    send_word(CMD_SET_DUTY, DUTY_CEIL);
    send_ticks(2);
  endtask

  task automatic test_period_changes();
    program_regs(20'd2, 20'd6, 20'd50, 20'd0);
    send_word(CMD_SET_DUTY, 7'd30);
    send_word(CMD_START, 7'd0);
    send_ticks(3);
    // count already past the new period
    program_regs(20'd2, 20'd6, 20'd2, 20'd0);
    send_ticks(1);
    send_word(CMD_START, 7'd0);
    send_ticks(2);
    send_word(CMD_STOP, 7'd0);
    send_word(CMD_SET_DUTY, 7'd20);
    send_word(CMD_START, 7'd0);
    send_ticks(2);
  endtask

  task automatic test_random_traffic();
    int          counted;
    int          phase_len;
    int          pick;
    cmd_t        c;
    logic [6:0]  d;
    logic [19:0] lo, hi, per, init;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0:       lo = '0;
        1:       lo = TIME_ALL_ONES;
        default: lo = 20'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       hi = '0;
        1:       hi = TIME_ALL_ONES;
        default: hi = 20'($urandom_range(0, 90));
      endcase
      case ($urandom_range(0, 7))
        0:       per = '0;
        1:       per = 20'd1;
        2:       per = TIME_ALL_ONES;
        default: per = 20'($urandom_range(2, 30));
      endcase
      case ($urandom_range(0, 4))
        0:       init = '0;
        1:       init = 20'd127;
        2:       init = 20'($urandom_range(0, 20'hfffff));
        default: init = 20'($urandom_range(0, 127));
      endcase
      program_regs(lo, hi, per, init);
      if ($urandom_range(0, 9) != 0) send_word(CMD_START, 7'($urandom_range(0, 127)));
      phase_len = $urandom_range(15, 80);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        d = 7'($urandom_range(0, 127));
        if (pick < 74) begin
          c = CMD_TICK;
        end else if (pick < 85) begin
          c = CMD_SET_DUTY;
          d = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
        end else if (pick < 92) begin
          c = CMD_START;
        end else begin
          c = CMD_STOP;
        end
        counted++;
        send_word(c, d);
      end
    end
  endtask

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_phase % 7) > 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pin_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with none expected: %h", out_data);
      end else begin
        want_word = pin_words_due.pop_front();
        if (out_data.pwm_out !== want_word.pwm_out || out_data.status !== want_word.status ||
            out_data.running !== want_word.running ||
            out_data.active_duty !== want_word.active_duty ||
            out_data.pulse_us !== want_word.pulse_us) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: expected pin %0b status %0b run %0b duty %0d pulse %0d,",
                   want_word.pwm_out, want_word.status, want_word.running,
                   want_word.active_duty, want_word.pulse_us);
            $display(" got pin %0b status %0b run %0b duty %0d pulse %0d",
                     out_data.pwm_out, out_data.status, out_data.running,
                     out_data.active_duty, out_data.pulse_us);
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_initial_duty_saturation();
    test_duty_commands();
    test_range_corners();
    test_period_changes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pin_words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
